@@ src/assert_macros.svh @@
// Assertion macros used by the checker in avk_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define AVK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Plain condition that holds at every rising edge outside reset.
`define AVK_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ src/avk_pkg.sv @@
package avk_pkg;

	localparam int IO_W = 32;
	localparam int FX_W = 48;
	localparam int SUM_W = 52;
	localparam int MO_W = 50;
	localparam int DT_W = 24;
	localparam int DEN_W = 49;

	localparam logic signed [FX_W-1:0] FX_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [FX_W-1:0] FX_MIN = 48'sh8000_0000_0000;
	localparam logic signed [SUM_W-1:0] SAT_HI = 52'sh0_7FFF_FFFF_FFFF;
	localparam logic signed [SUM_W-1:0] SAT_LO = 52'shF_8000_0000_0000;

	localparam logic [DT_W-1:0] STEP_TIME_RST = 24'd167772;
	localparam logic [IO_W-1:0] ALT_NOISE_RST = 32'd655;
	localparam logic [IO_W-1:0] VEL_NOISE_RST = 32'd6554;
	localparam logic [IO_W-1:0] MEAS_NOISE_RST = 32'd196608;
	localparam logic signed [IO_W-1:0] INIT_ALT_RST = 32'sd0;
	localparam logic signed [FX_W-1:0] VAR_RST = 48'sh0064_0000_0000;

	typedef enum logic [2:0] {
		REG_STEP_TIME  = 3'd0,
		REG_ALT_NOISE  = 3'd1,
		REG_VEL_NOISE  = 3'd2,
		REG_MEAS_NOISE = 3'd3,
		REG_INIT_ALT   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		SH_24,
		SH_25,
		SH_32
	} mul_shift_t;

	typedef struct packed {
		logic start;
		logic signed [MO_W-1:0] a;
		logic signed [MO_W-1:0] b;
		mul_shift_t sh;
	} mul_req_t;

	typedef struct packed {
		logic start;
		logic signed [FX_W-1:0] n;
		logic [DEN_W-1:0] d;
	} div_req_t;

	function automatic logic signed [FX_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
		logic signed [FX_W-1:0] r;
		if (v > SAT_HI) r = FX_MAX;
		else if (v < SAT_LO) r = FX_MIN;
		else r = v[FX_W-1:0];
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] ext52(input logic signed [FX_W-1:0] v);
		return {{(SUM_W-FX_W){v[FX_W-1]}}, v};
	endfunction

	function automatic logic signed [MO_W-1:0] ext50(input logic signed [FX_W-1:0] v);
		return {{(MO_W-FX_W){v[FX_W-1]}}, v};
	endfunction

	function automatic logic [IO_W-1:0] to_port(input logic signed [FX_W-1:0] v);
		logic [FX_W-1:0] mag;
		logic [IO_W:0] m;
		logic [IO_W-1:0] r;
		mag = v[FX_W-1] ? FX_W'(-v) : FX_W'(v);
		m = 33'(({1'b0, mag} + 49'h8000) >> 16);
		if (!v[FX_W-1]) r = (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[IO_W-1:0];
		else r = (m > 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - m);
		return r;
	endfunction

endpackage

@@ src/avk_if.sv @@
interface avk_in_if import avk_pkg::*;;
	logic valid;
	logic ready;
	logic signed [IO_W-1:0] accel;
	logic baro_valid;
	logic signed [IO_W-1:0] baro_altitude;

	modport source(output valid, accel, baro_valid, baro_altitude, input ready);
	modport sink(input valid, accel, baro_valid, baro_altitude, output ready);
endinterface

interface avk_out_if import avk_pkg::*;;
	logic valid;
	logic ready;
	logic signed [IO_W-1:0] altitude_estimate;
	logic signed [IO_W-1:0] velocity_estimate;

	modport source(output valid, altitude_estimate, velocity_estimate, input ready);
	modport sink(input valid, altitude_estimate, velocity_estimate, output ready);
endinterface

@@ src/avk_mul.sv @@
module avk_mul import avk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  mul_req_t req,
	output logic done,
	output logic signed [FX_W-1:0] prod
);

	localparam int DIG_W = 17;
	localparam int DIGITS = 3;
	localparam int BD_W = DIG_W * DIGITS;
	localparam int AM_W = MO_W - 1;
	localparam int ACC_W = AM_W + BD_W;
	localparam int PP_W = AM_W + DIG_W;
	localparam int R_W = ACC_W - 24;

	typedef enum logic [1:0] {M_IDLE, M_RUN, M_RND, M_SAT} mstate_t;

	mstate_t state_q;
	logic [AM_W-1:0] a_mag_q;
	logic [BD_W-1:0] b_dig_q;
	logic [ACC_W-1:0] acc_q;
	logic [R_W-1:0] r_q;
	logic [1:0] cnt_q;
	logic neg_q;
	mul_shift_t sh_q;
	logic done_q;
	logic signed [FX_W-1:0] prod_q;

	logic [MO_W-1:0] a_abs, b_abs;
	logic [PP_W-1:0] pp;
	logic [ACC_W-1:0] half, rsum, rshift;
	logic [R_W-1:0] cap;

	assign a_abs = req.a[MO_W-1] ? MO_W'(-req.a) : MO_W'(req.a);
	assign b_abs = req.b[MO_W-1] ? MO_W'(-req.b) : MO_W'(req.b);
	assign pp = PP_W'(a_mag_q) * PP_W'(b_dig_q[BD_W-1 -: DIG_W]);
	assign cap = R_W'(1) << (FX_W - 1);

	always_comb begin
		unique case (sh_q)
			SH_24: half = ACC_W'(1) << 23;
			SH_25: half = ACC_W'(1) << 24;
			SH_32: half = ACC_W'(1) << 31;
			default: half = '0;
		endcase
		rsum = acc_q + half;
		unique case (sh_q)
			SH_24: rshift = rsum >> 24;
			SH_25: rshift = rsum >> 25;
			SH_32: rshift = rsum >> 32;
			default: rshift = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			a_mag_q <= '0;
			b_dig_q <= '0;
			acc_q <= '0;
			r_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			sh_q <= SH_24;
			done_q <= 1'b0;
			prod_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_mag_q <= a_abs[AM_W-1:0];
						b_dig_q <= BD_W'(b_abs[AM_W-1:0]);
						neg_q <= req.a[MO_W-1] ^ req.b[MO_W-1];
						sh_q <= req.sh;
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					acc_q <= (acc_q << DIG_W) + ACC_W'(pp);
					b_dig_q <= b_dig_q << DIG_W;
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'(DIGITS - 1)) state_q <= M_RND;
				end
				M_RND: begin
					r_q <= rshift[R_W-1:0];
					state_q <= M_SAT;
				end
				M_SAT: begin
					if (neg_q) prod_q <= (r_q > cap) ? FX_MIN : FX_W'(R_W'(0) - r_q);
					else prod_q <= (r_q >= cap) ? FX_MAX : r_q[FX_W-1:0];
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

@@ src/avk_div.sv @@
module avk_div import avk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic done,
	output logic signed [FX_W-1:0] quot
);

	localparam int CHK_W = FX_W + 16;

	typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIN} dstate_t;

	dstate_t state_q;
	logic [FX_W-1:0] un_q;
	logic [DEN_W-1:0] ud_q;
	logic [DEN_W-1:0] rem_q;
	logic [FX_W-1:0] lo_q;
	logic [FX_W-1:0] q_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic cap_q;
	logic done_q;
	logic signed [FX_W-1:0] quot_q;

	logic [FX_W-1:0] n_abs;
	logic [DEN_W:0] trial;
	logic trial_ok;
	logic [DEN_W-1:0] mag;

	assign n_abs = req.n[FX_W-1] ? FX_W'(-req.n) : FX_W'(req.n);
	assign trial = {rem_q, lo_q[FX_W-1]};
	assign trial_ok = trial >= {1'b0, ud_q};
	assign mag = cap_q ? (DEN_W'(1) << (FX_W - 1)) : ((DEN_W'(q_q) + DEN_W'(1)) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			un_q <= '0;
			ud_q <= '0;
			rem_q <= '0;
			lo_q <= '0;
			q_q <= '0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			cap_q <= 1'b0;
			done_q <= 1'b0;
			quot_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.start) begin
						un_q <= n_abs;
						ud_q <= req.d;
						neg_q <= req.n[FX_W-1];
						state_q <= D_CHK;
					end
				end
				D_CHK: begin
					if (CHK_W'(un_q) >= {ud_q, 15'b0}) begin
						cap_q <= 1'b1;
						state_q <= D_FIN;
					end else begin
						cap_q <= 1'b0;
						rem_q <= DEN_W'(un_q >> 15);
						lo_q <= {un_q[14:0], 33'b0};
						cnt_q <= 6'(FX_W - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= trial_ok ? DEN_W'(trial - {1'b0, ud_q}) : trial[DEN_W-1:0];
					q_q <= {q_q[FX_W-2:0], trial_ok};
					lo_q <= lo_q << 1;
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) state_q <= D_FIN;
				end
				D_FIN: begin
					if (neg_q) quot_q <= FX_W'(DEN_W'(0) - mag);
					else quot_q <= mag[FX_W-1] ? FX_MAX : mag[FX_W-1:0];
					done_q <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

@@ src/altitude_velocity_kalman.sv @@
// Channel   Dir  Payload                                  Accepted when
// sample    in   accel, baro_valid, baro_altitude         valid && ready
// result    out  altitude_estimate, velocity_estimate     valid && ready
// apb       in   step_time .. initial_altitude at 4*i     psel && penable && pwrite
//
// Each item runs seven products on the shared multiplier; a barometer sample with
// positive variance adds six products and two divider quotients of up to 48 steps.
// sample.ready is high only while the sequencer is idle; a stalled result holds
// in the output register while the next item is taken.
// Reset loads the register defaults and the starting state and covariance.
module altitude_velocity_kalman import avk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	avk_in_if.sink sample,
	avk_out_if.source result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [4:0] {
		S_IDLE, S_DT2, S_ADT, S_VDT, S_HALF, S_PSUM, S_PDT2, S_P11DT,
		S_MEAS, S_K0, S_K1, S_U_ALT, S_U_VEL, S_U_P10, S_U_P11, S_U_P01,
		S_U_P00, S_OUT
	} state_t;

	state_t state_q;
	logic issued_q;

	logic [DT_W-1:0] step_time_q;
	logic [IO_W-1:0] alt_noise_q, vel_noise_q, meas_noise_q;
	logic signed [IO_W-1:0] init_alt_q;

	logic signed [FX_W-1:0] alt_q, vel_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [FX_W-1:0] dt2_q, adt_q, y_q, k0_q, k1_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [DEN_W-1:0] s_q;
	logic signed [IO_W-1:0] accel_q, meas_q;
	logic baro_q;

	logic out_valid_q;
	logic signed [IO_W-1:0] alt_out_q, vel_out_q;

	mul_req_t mreq;
	div_req_t dreq;
	logic mul_done, div_done;
	logic signed [FX_W-1:0] mprod, dquot;
	logic use_mul, use_div;

	logic signed [MO_W-1:0] dt50;
	logic signed [SUM_W-1:0] qa, qv, s_sum, y_sum;
	logic cfg_wr;

	assign dt50 = $signed(MO_W'(step_time_q));
	assign qa = $signed({4'b0000, alt_noise_q, 16'h0000});
	assign qv = $signed({4'b0000, vel_noise_q, 16'h0000});
	assign s_sum = ext52(p00_q) + $signed({4'b0000, meas_noise_q, 16'h0000});
	assign y_sum = ext52($signed({meas_q, 16'h0000})) - ext52(alt_q);
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		use_mul = 1'b1;
		use_div = 1'b0;
		mreq.a = '0;
		mreq.b = dt50;
		mreq.sh = SH_24;
		dreq.n = p00_q;
		dreq.d = s_q;
		unique case (state_q)
			S_DT2: mreq.a = dt50;
			S_ADT: mreq.a = ext50($signed({accel_q, 16'h0000}));
			S_VDT: mreq.a = ext50(vel_q);
			S_HALF: begin
				mreq.a = ext50(adt_q);
				mreq.sh = SH_25;
			end
			S_PSUM: mreq.a = ext50(p10_q) + ext50(p01_q);
			S_PDT2: begin
				mreq.a = ext50(p11_q);
				mreq.b = ext50(dt2_q);
			end
			S_P11DT: mreq.a = ext50(p11_q);
			S_K0: begin
				use_mul = 1'b0;
				use_div = 1'b1;
			end
			S_K1: begin
				use_mul = 1'b0;
				use_div = 1'b1;
				dreq.n = p10_q;
			end
			S_U_ALT: begin
				mreq.a = ext50(k0_q);
				mreq.b = ext50(y_q);
				mreq.sh = SH_32;
			end
			S_U_VEL: begin
				mreq.a = ext50(k1_q);
				mreq.b = ext50(y_q);
				mreq.sh = SH_32;
			end
			S_U_P10: begin
				mreq.a = ext50(k1_q);
				mreq.b = ext50(p00_q);
				mreq.sh = SH_32;
			end
			S_U_P11: begin
				mreq.a = ext50(k1_q);
				mreq.b = ext50(p01_q);
				mreq.sh = SH_32;
			end
			S_U_P01: begin
				mreq.a = ext50(k0_q);
				mreq.b = ext50(p01_q);
				mreq.sh = SH_32;
			end
			S_U_P00: begin
				mreq.a = ext50(k0_q);
				mreq.b = ext50(p00_q);
				mreq.sh = SH_32;
			end
			default: use_mul = 1'b0;
		endcase
		mreq.start = use_mul && !issued_q;
		dreq.start = use_div && !issued_q;
	end

	avk_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mul_done),
		.prod(mprod)
	);

	avk_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.done(div_done),
		.quot(dquot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			step_time_q <= STEP_TIME_RST;
			alt_noise_q <= ALT_NOISE_RST;
			vel_noise_q <= VEL_NOISE_RST;
			meas_noise_q <= MEAS_NOISE_RST;
			init_alt_q <= INIT_ALT_RST;
			alt_q <= '0;
			vel_q <= '0;
			p00_q <= VAR_RST;
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= VAR_RST;
			dt2_q <= '0;
			adt_q <= '0;
			y_q <= '0;
			k0_q <= '0;
			k1_q <= '0;
			sum_q <= '0;
			s_q <= '0;
			accel_q <= '0;
			meas_q <= '0;
			baro_q <= 1'b0;
			out_valid_q <= 1'b0;
			alt_out_q <= '0;
			vel_out_q <= '0;
		end else begin
			if (mreq.start || dreq.start) issued_q <= 1'b1;
			if (mul_done || div_done) issued_q <= 1'b0;
			if (out_valid_q && result.ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						accel_q <= sample.accel;
						baro_q <= sample.baro_valid;
						meas_q <= sample.baro_altitude;
						state_q <= S_DT2;
					end
				end
				S_DT2: if (mul_done) begin
					dt2_q <= mprod;
					state_q <= S_ADT;
				end
				S_ADT: if (mul_done) begin
					adt_q <= mprod;
					state_q <= S_VDT;
				end
				S_VDT: if (mul_done) begin
					sum_q <= ext52(alt_q) + ext52(mprod);
					state_q <= S_HALF;
				end
				S_HALF: if (mul_done) begin
					alt_q <= sat48(sum_q + ext52(mprod));
					vel_q <= sat48(ext52(vel_q) + ext52(adt_q));
					state_q <= S_PSUM;
				end
				S_PSUM: if (mul_done) begin
					sum_q <= ext52(p00_q) + ext52(mprod) + qa;
					state_q <= S_PDT2;
				end
				S_PDT2: if (mul_done) begin
					p00_q <= sat48(sum_q + ext52(mprod));
					state_q <= S_P11DT;
				end
				S_P11DT: if (mul_done) begin
					p01_q <= sat48(ext52(p01_q) + ext52(mprod));
					p10_q <= sat48(ext52(p10_q) + ext52(mprod));
					p11_q <= sat48(ext52(p11_q) + qv);
					state_q <= baro_q ? S_MEAS : S_OUT;
				end
				S_MEAS: begin
					y_q <= sat48(y_sum);
					s_q <= s_sum[DEN_W-1:0];
					state_q <= (!s_sum[SUM_W-1] && (s_sum != '0)) ? S_K0 : S_OUT;
				end
				S_K0: if (div_done) begin
					k0_q <= dquot;
					state_q <= S_K1;
				end
				S_K1: if (div_done) begin
					k1_q <= dquot;
					state_q <= S_U_ALT;
				end
				S_U_ALT: if (mul_done) begin
					alt_q <= sat48(ext52(alt_q) + ext52(mprod));
					state_q <= S_U_VEL;
				end
				S_U_VEL: if (mul_done) begin
					vel_q <= sat48(ext52(vel_q) + ext52(mprod));
					state_q <= S_U_P10;
				end
				S_U_P10: if (mul_done) begin
					p10_q <= sat48(ext52(p10_q) - ext52(mprod));
					state_q <= S_U_P11;
				end
				S_U_P11: if (mul_done) begin
					p11_q <= sat48(ext52(p11_q) - ext52(mprod));
					state_q <= S_U_P01;
				end
				S_U_P01: if (mul_done) begin
					p01_q <= sat48(ext52(p01_q) - ext52(mprod));
					state_q <= S_U_P00;
				end
				S_U_P00: if (mul_done) begin
					p00_q <= sat48(ext52(p00_q) - ext52(mprod));
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						alt_out_q <= $signed(to_port(alt_q));
						vel_out_q <= $signed(to_port(vel_q));
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_STEP_TIME: step_time_q <= pwdata[DT_W-1:0];
					REG_ALT_NOISE: alt_noise_q <= pwdata;
					REG_VEL_NOISE: vel_noise_q <= pwdata;
					REG_MEAS_NOISE: meas_noise_q <= pwdata;
					REG_INIT_ALT: begin
						init_alt_q <= $signed(pwdata);
						alt_q <= $signed({pwdata, 16'h0000});
						vel_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_STEP_TIME: prdata = 32'(step_time_q);
			REG_ALT_NOISE: prdata = alt_noise_q;
			REG_VEL_NOISE: prdata = vel_noise_q;
			REG_MEAS_NOISE: prdata = meas_noise_q;
			REG_INIT_ALT: prdata = init_alt_q;
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign sample.ready = (state_q == S_IDLE);
	assign result.valid = out_valid_q;
	assign result.altitude_estimate = alt_out_q;
	assign result.velocity_estimate = vel_out_q;

endmodule

@@ src/avk_checker.sv @@
`include "assert_macros.svh"

module avk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic pready
);

	`AVK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled result item lost")
	`AVK_ASSERT(a_busy_after_take, in_valid && in_ready |=> !in_ready, "item taken while busy")
	`AVK_ASSERT_ALWAYS(a_in_ready_known, !$isunknown(in_ready), "sample ready unknown")
	`AVK_ASSERT_ALWAYS(a_pready_high, pready, "config port stalled")

endmodule

bind altitude_velocity_kalman avk_checker u_avk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.pready(pready)
);

@@ test/altitude_velocity_kalman_checker.sv @@
module altitude_velocity_kalman_checker import avk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	avk_in_if sample,
	avk_out_if result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic pready,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output int mismatches,
	output int pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [127:0] wide_t;
	typedef struct {
		logic [31:0] altitude;
		logic [31:0] velocity;
	} estimate_t;

	localparam wide_t Q_MAX = wide_t'(FX_MAX);
	localparam wide_t Q_MIN = wide_t'(FX_MIN);

	estimate_t estimates_q[$];

	logic [23:0] step_time;
	logic [31:0] altitude_noise;
	logic [31:0] velocity_noise;
	logic [31:0] measure_noise;

	wide_t altitude_q, velocity_q, var_alt, cov_av, cov_va, var_vel;

	function automatic wide_t clamp48(input wide_t v);
		if (v > Q_MAX) return Q_MAX;
		if (v < Q_MIN) return Q_MIN;
		return v;
	endfunction

	function automatic wide_t apply_sign(input bit neg, input logic [127:0] mag);
		logic [127:0] m;
		m = (mag > (128'd1 << 47)) ? (128'd1 << 47) : mag;
		return clamp48(neg ? -wide_t'(m) : wide_t'(m));
	endfunction

	function automatic wide_t round_mul(input wide_t a, input wide_t b, input int sh);
		logic [127:0] ma, mb, mag;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		mag = (ma * mb + (128'd1 << (sh - 1))) >> sh;
		return apply_sign((a < 0) != (b < 0), mag);
	endfunction

	function automatic wide_t round_div(input wide_t n, input wide_t d);
		logic [127:0] mn, md, mag;
		mn = (n < 0) ? -n : n;
		md = d;
		mag = (((mn << 33) / md) + 128'd1) >> 1;
		return apply_sign(n < 0, mag);
	endfunction

	function automatic logic [31:0] port_value(input wide_t v);
		logic [127:0] mag, m;
		logic [31:0] r;
		mag = (v < 0) ? -v : v;
		m = (mag + 128'd32768) >> 16;
		if (v >= 0) begin
			r = (m > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
		end else begin
			r = m[31:0];
			r = (m > 128'h8000_0000) ? 32'h8000_0000 : -r;
		end
		return r;
	endfunction

	function automatic void filter_step(input logic signed [31:0] accel, input logic baro_ok,
			input logic signed [31:0] baro_alt);
		wide_t dt, dt2, acc, qa, qv, adt, p00, p01, p10, p11, p11dt;
		wide_t meas, innov, s, k0, k1, o00, o01;
		estimate_t e;
		dt = wide_t'(step_time);
		dt2 = (dt * dt + (wide_t'(1) << 23)) >>> 24;
		acc = wide_t'(accel) <<< 16;
		qa = wide_t'(altitude_noise) <<< 16;
		qv = wide_t'(velocity_noise) <<< 16;
		adt = round_mul(acc, dt, 24);
		p00 = var_alt;
		p01 = cov_av;
		p10 = cov_va;
		p11 = var_vel;
		p11dt = round_mul(p11, dt, 24);
		altitude_q = clamp48(altitude_q + round_mul(velocity_q, dt, 24) + round_mul(adt, dt, 25));
		velocity_q = clamp48(velocity_q + adt);
		var_alt = clamp48(p00 + round_mul(p10 + p01, dt, 24) + round_mul(p11, dt2, 24) + qa);
		cov_av = clamp48(p01 + p11dt);
		cov_va = clamp48(p10 + p11dt);
		var_vel = clamp48(p11 + qv);
		if (baro_ok) begin
			meas = wide_t'(baro_alt) <<< 16;
			innov = clamp48(meas - altitude_q);
			s = var_alt + (wide_t'(measure_noise) <<< 16);
			if (s > 0) begin
				k0 = round_div(var_alt, s);
				k1 = round_div(cov_va, s);
				o00 = var_alt;
				o01 = cov_av;
				altitude_q = clamp48(altitude_q + round_mul(k0, innov, 32));
				velocity_q = clamp48(velocity_q + round_mul(k1, innov, 32));
				var_alt = clamp48(o00 - round_mul(k0, o00, 32));
				cov_av = clamp48(o01 - round_mul(k0, o01, 32));
				cov_va = clamp48(cov_va - round_mul(k1, o00, 32));
				var_vel = clamp48(var_vel - round_mul(k1, o01, 32));
			end
		end
		e.altitude = port_value(altitude_q);
		e.velocity = port_value(velocity_q);
		estimates_q.push_back(e);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t e;
		if (!arst_n) begin
			step_time <= STEP_TIME_RST;
			altitude_noise <= ALT_NOISE_RST;
			velocity_noise <= VEL_NOISE_RST;
			measure_noise <= MEAS_NOISE_RST;
			altitude_q = 0;
			velocity_q = 0;
			var_alt = wide_t'(VAR_RST);
			cov_av = 0;
			cov_va = 0;
			var_vel = wide_t'(VAR_RST);
			estimates_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
				case (paddr[4:2])
					REG_STEP_TIME: step_time <= pwdata[23:0];
					REG_ALT_NOISE: altitude_noise <= pwdata;
					REG_VEL_NOISE: velocity_noise <= pwdata;
					REG_MEAS_NOISE: measure_noise <= pwdata;
					REG_INIT_ALT: begin
						altitude_q = wide_t'($signed(pwdata)) <<< 16;
						velocity_q = 0;
					end
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (estimates_q.size() == 0) begin
					$error("unexpected item: altitude_estimate %h velocity_estimate %h",
						result.altitude_estimate, result.velocity_estimate);
					mismatches++;
				end else begin
					e = estimates_q.pop_front();
					if (result.altitude_estimate !== e.altitude) begin
						$error("altitude_estimate expected %h actual %h", e.altitude,
							result.altitude_estimate);
						mismatches++;
					end
					if (result.velocity_estimate !== e.velocity) begin
						$error("velocity_estimate expected %h actual %h", e.velocity,
							result.velocity_estimate);
						mismatches++;
					end
				end
			end
			if (sample.valid && sample.ready)
				filter_step(sample.accel, sample.baro_valid, sample.baro_altitude);
			pending <= estimates_q.size();
		end
	end
endmodule

@@ test/altitude_velocity_kalman_test.sv @@
module altitude_velocity_kalman_test;
	import avk_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 180;
	localparam logic [2:0] UNMAPPED_IDX = 3'd6;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int mismatches;
	int pending;
	int burst_left;
	int idle_cycles;
	int stall_mode;
	int mode_cycles;

	avk_in_if sample_ch();
	avk_out_if result_ch();

	altitude_velocity_kalman dut (
		.clk(clk), .arst_n(arst_n), .sample(sample_ch), .result(result_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	altitude_velocity_kalman_checker checker_i (
		.clk(clk), .arst_n(arst_n), .sample(sample_ch), .result(result_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata), .mismatches(mismatches), .pending(pending)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_cycles <= $urandom_range(50, 400);
		end else begin
			mode_cycles <= mode_cycles - 1;
		end
		case (stall_mode)
			0: result_ch.ready <= 1'b1;
			1: result_ch.ready <= 1'($urandom_range(0, 1));
			default: result_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
				|| psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send_item(input logic signed [31:0] accel, input logic baro_ok,
			input logic signed [31:0] baro_alt);
		if (burst_left == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		sample_ch.valid <= 1'b1;
		sample_ch.accel <= accel;
		sample_ch.baro_valid <= baro_ok;
		sample_ch.baro_altitude <= baro_alt;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [31:0] pick_accel();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 2621440)) - 1310720);
	endfunction

	function automatic logic [31:0] pick_baro();
		if ($urandom_range(0, 9) == 0) return $urandom;
		return 32'($signed($urandom_range(0, 26214400)) - 13107200);
	endfunction

	initial begin
		logic [31:0] step_v[PHASES] = '{0, 1, 32'h00FF_FFFF, 167772, 0, 0, 0, 0};
		logic [31:0] alt_n[PHASES] = '{0, 32'hFFFF_FFFF, 655, 0, 0, 0, 0, 0};
		logic [31:0] vel_n[PHASES] = '{0, 32'hFFFF_FFFF, 0, 6554, 0, 0, 0, 0};
		logic [31:0] meas_n[PHASES] = '{0, 32'hFFFF_FFFF, 1, 196608, 0, 0, 0, 0};
		logic [31:0] init_a[PHASES] = '{0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0};
		int pause_at;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.accel = '0;
		sample_ch.baro_valid = 1'b0;
		sample_ch.baro_altitude = '0;
		result_ch.ready = 1'b0;
		burst_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		mode_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(0, 1'b0, 0);
		send_item(32'h7FFF_FFFF, 1'b0, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
		send_item(32'h8000_0000, 1'b1, 32'h8000_0000);
		send_item(1, 1'b1, 0);
		send_item(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
		send_item(32'h0009_CCCD, 1'b1, 32'h0064_0000);
		send_item(32'hFFF6_3333, 1'b0, 32'h0064_0000);
		send_item(0, 1'b1, 32'h0064_0000);
		send_item(32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
		send_item(32'hAAAA_AAAA, 1'b1, 32'h5555_5555);
		drain();
		write_reg(REG_STEP_TIME, 32'h00FF_FFFF);
		write_reg(REG_ALT_NOISE, 0);
		write_reg(REG_VEL_NOISE, 0);
		write_reg(REG_MEAS_NOISE, 0);
		write_reg(UNMAPPED_IDX, 32'hFFFF_FFFF);
		repeat (4) send_item(32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
		repeat (4) send_item(32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
		send_item(0, 1'b1, 0);
		send_item(0, 1'b0, 0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			if (p >= 4) begin
				step_v[p] = $urandom_range(1, 1677721);
				alt_n[p] = $urandom_range(0, 65536);
				vel_n[p] = $urandom_range(0, 655360);
				meas_n[p] = $urandom_range(1, 6553600);
				init_a[p] = $urandom;
			end
			write_reg(REG_STEP_TIME, step_v[p]);
			write_reg(REG_ALT_NOISE, alt_n[p]);
			write_reg(REG_VEL_NOISE, vel_n[p]);
			write_reg(REG_MEAS_NOISE, meas_n[p]);
			write_reg(REG_INIT_ALT, init_a[p]);
			pause_at = $urandom_range(20, PHASE_ITEMS - 20);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == pause_at) begin
					sample_ch.valid <= 1'b0;
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
				send_item(pick_accel(), 1'($urandom_range(0, 1)), pick_baro());
			end
		end

		drain();
		repeat (250) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+src
src/avk_pkg.sv
src/avk_if.sv
src/avk_mul.sv
src/avk_div.sv
src/altitude_velocity_kalman.sv
src/avk_checker.sv
test/altitude_velocity_kalman_checker.sv
test/altitude_velocity_kalman_test.sv
